[src/cihd_pkg.sv]
// ----------------------------------------------------------------------------
// CBOR integer head decoder package
// Shared types and constants for the front, queue and back of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cihd_pkg;

   localparam logic [2:0] MAJOR_NEGATIVE = 3'h1;
   localparam logic [4:0] INFO_LAST_IMMEDIATE = 5'd23;
   localparam logic [4:0] INFO_LAST_SIZED = 5'd27;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_TYPE  = 2'd1,
      ST_RESERVED  = 2'd2,
      ST_TRUNCATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_ARG    = 2'd1,
      PH_SKIP   = 2'd2
   } phase_type;

   typedef enum logic {
      OP_HEAD = 1'b0,
      OP_ARG  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ARG_ZERO = 2'd0,
      ARG_INFO = 2'd1,
      ARG_ACC  = 2'd2
   } arg_sel_type;

   typedef struct packed {
      op_type      op;
      logic        emit;
      status_type  status;
      logic        negative;
      logic [3:0]  head_bytes;
      arg_sel_type arg_sel;
      logic [7:0]  data;
   } entry_type;

endpackage

`default_nettype wire

[src/cihd_front.sv]
// ----------------------------------------------------------------------------
// CBOR integer head decoder front
// Accepts bytes, tracks the frame phase and counters, and issues one
// classified operation per byte of the head into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cihd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 frame_end,
   output logic                      push,
   output cihd_pkg::entry_type       push_entry
);

   cihd_pkg::phase_type phase_ff, phase_in;
   logic       negative_ff, negative_in;
   logic [3:0] needed_ff, needed_in;
   logic [3:0] taken_ff, taken_in;

   logic [2:0] major;
   logic [4:0] info;
   logic [3:0] taken_next;
   logic       is_bad_type;
   logic       is_immediate;
   logic       is_reserved;
   logic       arg_done;

   assign major        = data_byte[7:5];
   assign info         = data_byte[4:0];
   assign taken_next   = taken_ff + 4'd1;
   assign is_bad_type  = major > cihd_pkg::MAJOR_NEGATIVE;
   assign is_immediate = info <= cihd_pkg::INFO_LAST_IMMEDIATE;
   assign is_reserved  = info > cihd_pkg::INFO_LAST_SIZED;
   assign arg_done     = taken_next >= needed_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            cihd_pkg::PH_ARG: begin
               if (arg_done) begin
                  phase_in = frame_end ? cihd_pkg::PH_HEADER : cihd_pkg::PH_SKIP;
               end else if (frame_end) begin
                  phase_in = cihd_pkg::PH_HEADER;
               end
            end
            cihd_pkg::PH_SKIP: begin
               if (frame_end) begin
                  phase_in = cihd_pkg::PH_HEADER;
               end
            end
            default: begin
               if (is_bad_type || is_immediate || is_reserved || frame_end) begin
                  phase_in = frame_end ? cihd_pkg::PH_HEADER : cihd_pkg::PH_SKIP;
               end else begin
                  phase_in = cihd_pkg::PH_ARG;
               end
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      push                  = 1'b0;
      push_entry.op         = cihd_pkg::OP_HEAD;
      push_entry.emit       = 1'b0;
      push_entry.status     = cihd_pkg::ST_OK;
      push_entry.negative   = negative_ff;
      push_entry.head_bytes = 4'd1;
      push_entry.arg_sel    = cihd_pkg::ARG_ZERO;
      push_entry.data       = data_byte;
      case (phase_ff)
         cihd_pkg::PH_ARG: begin
            push          = accept;
            push_entry.op = cihd_pkg::OP_ARG;
            if (arg_done) begin
               push_entry.emit       = 1'b1;
               push_entry.arg_sel    = cihd_pkg::ARG_ACC;
               push_entry.head_bytes = needed_ff + 4'd1;
            end else if (frame_end) begin
               push_entry.emit       = 1'b1;
               push_entry.status     = cihd_pkg::ST_TRUNCATED;
               push_entry.head_bytes = taken_next + 4'd1;
            end
         end
         cihd_pkg::PH_SKIP: begin
            push = 1'b0;
         end
         default: begin
            push                = accept;
            push_entry.emit     = 1'b1;
            push_entry.negative = major[0];
            if (is_bad_type) begin
               push_entry.status   = cihd_pkg::ST_BAD_TYPE;
               push_entry.negative = 1'b0;
            end else if (is_immediate) begin
               push_entry.arg_sel = cihd_pkg::ARG_INFO;
            end else if (is_reserved) begin
               push_entry.status = cihd_pkg::ST_RESERVED;
            end else if (frame_end) begin
               push_entry.status = cihd_pkg::ST_TRUNCATED;
            end else begin
               push_entry.emit = 1'b0;
            end
         end
      endcase
   end

   // counters
   always_comb begin
      negative_in = negative_ff;
      needed_in   = needed_ff;
      taken_in    = taken_ff;
      if (accept) begin
         case (phase_ff)
            cihd_pkg::PH_ARG: begin
               taken_in = taken_next;
            end
            cihd_pkg::PH_SKIP: begin
               taken_in = taken_ff;
            end
            default: begin
               taken_in    = 4'd0;
               negative_in = is_bad_type ? 1'b0 : major[0];
               needed_in   = 4'd0;
               if (!is_bad_type && !is_immediate && !is_reserved) begin
                  needed_in = 4'd1 << info[1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cihd_pkg::PH_HEADER;
         negative_ff <= 1'b0;
         needed_ff   <= 4'd0;
         taken_ff    <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         needed_ff   <= needed_in;
         taken_ff    <= taken_in;
      end
   end

endmodule

`default_nettype wire

[src/cihd_queue.sv]
// ----------------------------------------------------------------------------
// CBOR integer head decoder queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cihd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cihd_pkg::entry_type  push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output cihd_pkg::entry_type       pop_entry,
   output logic                      not_empty
);

   cihd_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[src/cihd_back.sv]
// ----------------------------------------------------------------------------
// CBOR integer head decoder back
// Builds the argument from queued operations and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cihd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 entry_valid,
   input  wire cihd_pkg::entry_type  entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_is_negative,
   output logic [63:0]               rsp_argument,
   output logic [3:0]                rsp_head_bytes
);

   logic [63:0] acc_ff, acc_in;
   logic [63:0] shifted;
   logic        valid_ff, valid_in;
   logic [1:0]  status_ff;
   logic        negative_ff;
   logic [63:0] argument_ff, argument_in;
   logic [3:0]  head_bytes_ff;
   logic        load;

   assign shifted = {acc_ff[55:0], entry.data};
   assign pop     = entry_valid && (!entry.emit || !valid_ff || !rsp_stall);
   assign load    = pop && entry.emit;

   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         acc_in = (entry.op == cihd_pkg::OP_HEAD) ? 64'd0 : shifted;
      end
      case (entry.arg_sel)
         cihd_pkg::ARG_INFO: argument_in = {59'd0, entry.data[4:0]};
         cihd_pkg::ARG_ACC:  argument_in = shifted;
         default:            argument_in = 64'd0;
      endcase
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= 64'd0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff     <= entry.status;
         negative_ff   <= entry.negative;
         argument_ff   <= argument_in;
         head_bytes_ff <= entry.head_bytes;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_is_negative = negative_ff;
   assign rsp_argument    = argument_ff;
   assign rsp_head_bytes  = head_bytes_ff;

endmodule

`default_nettype wire

[src/cbor_integer_head_decoder.sv]
// ----------------------------------------------------------------------------
// CBOR integer head decoder
// Result path: the head's last byte is queued, then loaded into the result register.
// Throughput: one byte per cycle; while a result waits on rsp_stall, bytes keep
// flowing until a further result and one more entry fill the two-entry queue.
// Reset: synchronous; the decoder returns to awaiting a header byte and the
// queue and result register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cbor_integer_head_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_is_negative,
   output logic [63:0]      rsp_argument,
   output logic [3:0]       rsp_head_bytes
);

   cihd_pkg::entry_type push_entry;
   cihd_pkg::entry_type pop_entry;
   logic push;
   logic pop;
   logic full;
   logic not_empty;
   logic accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   cihd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .frame_end  (req_frame_end),
      .push       (push),
      .push_entry (push_entry)
   );

   cihd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (not_empty)
   );

   cihd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .entry_valid     (not_empty),
      .entry           (pop_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_is_negative (rsp_is_negative),
      .rsp_argument    (rsp_argument),
      .rsp_head_bytes  (rsp_head_bytes)
   );

endmodule

`default_nettype wire

[sim/cbor_integer_head_decoder_tb.sv]
// ----------------------------------------------------------------------------
// CBOR integer head decoder testbench
// Streams encoded frames into the decoder one byte per transfer and checks
// every decoded head against an in-bench decoder. Directed frames cover the
// immediate, sized, truncated, reserved and unsupported heads and trailing
// bytes; random frames follow with random gaps on both channels.
// ----------------------------------------------------------------------------

module cbor_integer_head_decoder_tb;

   localparam logic [4:0] INFO_FIRST_SIZED = 5'd24;
   localparam int IDLE_PCT = 23;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int CALM_START = 800;
   localparam int CALM_STOP = 1300;
   localparam int STREAM_BYTES = 1450;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       pause;
   } stream_byte_type;

   typedef struct packed {
      cihd_pkg::status_type status;
      logic                 negative;
      logic [63:0]          argument;
      logic [3:0]           head_bytes;
   } decoded_head_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_is_negative;
   logic [63:0] rsp_argument;
   logic [3:0]  rsp_head_bytes;

   stream_byte_type  byte_stream[$];
   decoded_head_type pending_heads[$];

   cihd_pkg::phase_type dec_phase = cihd_pkg::PH_HEADER;
   logic        dec_negative = 1'b0;
   logic [3:0]  dec_need = 4'd0;
   logic [3:0]  dec_got = 4'd0;
   logic [63:0] dec_acc = 64'd0;

   bit took_byte = 1'b0;
   bit calm = 1'b0;
   int cycle_count = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   cbor_integer_head_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_is_negative (rsp_is_negative),
      .rsp_argument    (rsp_argument),
      .rsp_head_bytes  (rsp_head_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic decode_byte(input logic [7:0] b, input logic last);
      decoded_head_type head;
      logic [2:0]  major;
      logic [4:0]  info;
      bit          produced;
      head = '0;
      produced = 1'b0;
      major = b[7:5];
      info = b[4:0];
      case (dec_phase)
         cihd_pkg::PH_SKIP: begin
            if (last) dec_phase = cihd_pkg::PH_HEADER;
         end
         cihd_pkg::PH_ARG: begin
            dec_acc = {dec_acc[55:0], b};
            dec_got = dec_got + 4'd1;
            if (dec_got >= dec_need) begin
               head.status = cihd_pkg::ST_OK;
               head.negative = dec_negative;
               head.argument = dec_acc;
               head.head_bytes = dec_need + 4'd1;
               produced = 1'b1;
               dec_phase = last ? cihd_pkg::PH_HEADER : cihd_pkg::PH_SKIP;
            end else if (last) begin
               head.status = cihd_pkg::ST_TRUNCATED;
               head.negative = dec_negative;
               head.head_bytes = dec_got + 4'd1;
               produced = 1'b1;
               dec_phase = cihd_pkg::PH_HEADER;
            end
         end
         default: begin
            dec_acc = 64'd0;
            dec_got = 4'd0;
            dec_need = 4'd0;
            head.head_bytes = 4'd1;
            produced = 1'b1;
            if (major > cihd_pkg::MAJOR_NEGATIVE) begin
               dec_negative = 1'b0;
               head.status = cihd_pkg::ST_BAD_TYPE;
               dec_phase = last ? cihd_pkg::PH_HEADER : cihd_pkg::PH_SKIP;
            end else begin
               dec_negative = major[0];
               head.negative = major[0];
               if (info <= cihd_pkg::INFO_LAST_IMMEDIATE) begin
                  head.status = cihd_pkg::ST_OK;
                  head.argument = {59'd0, info};
                  dec_phase = last ? cihd_pkg::PH_HEADER : cihd_pkg::PH_SKIP;
               end else if (info > cihd_pkg::INFO_LAST_SIZED) begin
                  head.status = cihd_pkg::ST_RESERVED;
                  dec_phase = last ? cihd_pkg::PH_HEADER : cihd_pkg::PH_SKIP;
               end else begin
                  dec_need = 4'd1 << (info - INFO_FIRST_SIZED);
                  if (last) begin
                     head.status = cihd_pkg::ST_TRUNCATED;
                     dec_phase = cihd_pkg::PH_HEADER;
                  end else begin
                     produced = 1'b0;
                     dec_phase = cihd_pkg::PH_ARG;
                  end
               end
            end
         end
      endcase
      if (produced) pending_heads.push_back(head);
   endtask

   task automatic queue_frame(input logic [7:0] frame[$], input bit pause);
      for (int i = 0; i < frame.size(); i++) begin
         byte_stream.push_back('{data: frame[i], last: (i == frame.size() - 1),
                                 pause: (i == 0) && pause});
      end
   endtask

   function automatic logic [7:0] arg_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // transfer bookkeeping, prediction and result checking
   always @(posedge clock) begin
      took_byte = !reset && req_valid && !req_stall;
      if (took_byte) decode_byte(req_data_byte, req_frame_end);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_heads.size() == 0) begin
            $error("unexpected result: status %0d argument %0h", rsp_status, rsp_argument);
            mismatches++;
         end else begin
            decoded_head_type want;
            want = pending_heads.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_is_negative !== want.negative) begin
               $error("is_negative expected %0d got %0d", want.negative, rsp_is_negative);
               mismatches++;
            end
            if (rsp_argument !== want.argument) begin
               $error("argument expected %0h got %0h", want.argument, rsp_argument);
               mismatches++;
            end
            if (rsp_head_bytes !== want.head_bytes) begin
               $error("head_bytes expected %0d got %0d", want.head_bytes, rsp_head_bytes);
               mismatches++;
            end
         end
      end
      if (!reset) cycle_count++;
      calm = cycle_count >= CALM_START && cycle_count < CALM_STOP;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || took_byte) begin
         if (byte_stream.size() != 0 && !(byte_stream[0].pause && pending_heads.size() != 0)
             && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid <= 1'b1;
            req_data_byte <= byte_stream[0].data;
            req_frame_end <= byte_stream[0].last;
            void'(byte_stream.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && $urandom_range(99) < IDLE_PCT;
      end
   end

   initial begin
      logic [7:0] frame[$];
      logic [4:0] info;
      int         kind;
      int         need;
      int         counted;
      int         frame_count;

      frame = {8'h00};
      queue_frame(frame, 1'b0);
      frame = {8'h37};
      queue_frame(frame, 1'b0);
      frame = {8'h18, 8'hFF};
      queue_frame(frame, 1'b0);
      frame = {8'h3B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      queue_frame(frame, 1'b0);
      frame = {8'h5F};
      queue_frame(frame, 1'b0);
      frame = {8'hFF, 8'h00};
      queue_frame(frame, 1'b0);
      frame = {8'h3C};
      queue_frame(frame, 1'b0);
      frame = {8'h1A, 8'h12, 8'h34};
      queue_frame(frame, 1'b0);
      frame = {8'h19};
      queue_frame(frame, 1'b0);
      frame = {8'h01, 8'hAA, 8'h55};
      queue_frame(frame, 1'b0);

      counted = 0;
      frame_count = 0;
      while (counted < STREAM_BYTES) begin
         frame.delete();
         kind = $urandom_range(99);
         if (kind < 70) begin
            info = $urandom_range(1) ? 5'($urandom_range(27, 24)) : 5'($urandom_range(27));
            frame.push_back({2'b00, 1'($urandom), info});
            need = info > cihd_pkg::INFO_LAST_IMMEDIATE ? 1 << (info - INFO_FIRST_SIZED) : 0;
            repeat (need) frame.push_back(arg_byte());
         end else if (kind < 80) begin
            info = 5'($urandom_range(27, 24));
            frame.push_back({2'b00, 1'($urandom), info});
            need = 1 << (info - INFO_FIRST_SIZED);
            repeat ($urandom_range(need - 1)) frame.push_back(arg_byte());
         end else if (kind < 90) begin
            frame.push_back({3'($urandom_range(7, 2)), 5'($urandom)});
         end else begin
            frame.push_back({2'b00, 1'($urandom), 5'($urandom_range(31, 28))});
         end
         if ((kind < 70 || kind >= 80) && $urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) frame.push_back(8'($urandom));
         end
         counted += frame.size();
         queue_frame(frame, frame_count == 40 || frame_count == 300);
         frame_count++;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_valid || pending_heads.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
src/cihd_pkg.sv
src/cihd_front.sv
src/cihd_queue.sv
src/cihd_back.sv
src/cbor_integer_head_decoder.sv
sim/cbor_integer_head_decoder_tb.sv
